// File: hdl/lkvc_pkg.sv
// lkvc_pkg: request and result types and fixed constants for the LRU key-value cache.
// No dependencies; used by lkvc_table and lru_key_value_cache.
`timescale 1ns / 1ps

package lkvc_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

   typedef enum logic {
      REQ_GET = 1'b0,
      REQ_PUT = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type        kind;
      logic [KEY_W-1:0]    key;
      logic [VAL_W-1:0]    value;
   } request_type;

   typedef struct packed {
      logic                hit;
      logic [VAL_W-1:0]    read_value;
      logic                evicted;
      logic [KEY_W-1:0]    evicted_key;
   } result_type;

endpackage

// File: hdl/lkvc_table.sv
// lkvc_table: entry registers, parallel key match and LRU rank update for the cache.
// Depends on lkvc_pkg. Result is combinational from the current request and table state.
`timescale 1ns / 1ps

module lkvc_table
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CAP_W-1:0]   capacity,
   input  logic               step,
   input  request_type        request,
   output result_type         result
);

   localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OW = $clog2(MAX_ENTRIES + 1);
   localparam int CW = (OW > CAP_W) ? OW : CAP_W;

   logic [MAX_ENTRIES-1:0]   valid_ff, valid_in;
   logic [RW-1:0]            rank_ff [MAX_ENTRIES];
   logic [RW-1:0]            rank_in [MAX_ENTRIES];
   logic [KEY_W-1:0]         key_ff  [MAX_ENTRIES];
   logic [KEY_W-1:0]         key_in  [MAX_ENTRIES];
   logic [VAL_W-1:0]         value_ff[MAX_ENTRIES];
   logic [VAL_W-1:0]         value_in[MAX_ENTRIES];
   logic [OW-1:0]            occ_ff, occ_in;

   logic [MAX_ENTRIES-1:0]   match;
   logic [MAX_ENTRIES-1:0]   lru_sel;
   logic [MAX_ENTRIES-1:0]   valid_b;
   logic [MAX_ENTRIES-1:0]   free_vec;
   logic [MAX_ENTRIES-1:0]   free_onehot;
   logic [RW-1:0]            rank_a  [MAX_ENTRIES];
   logic [RW-1:0]            hit_rank;
   logic [RW-1:0]            lru_rank;
   logic [VAL_W-1:0]         hit_value;
   logic [KEY_W-1:0]         victim_key;
   logic [CW-1:0]            cap_w, cap_eff, occ_w;
   logic                     hit, is_put, evict, insert;

   assign is_put = (request.kind == REQ_PUT);

   // capacity clipped to 1..MAX_ENTRIES
   always_comb begin
      cap_w = CW'(capacity);
      if (cap_w == '0) begin
         cap_eff = CW'(1);
      end else if (cap_w > CW'(MAX_ENTRIES)) begin
         cap_eff = CW'(MAX_ENTRIES);
      end else begin
         cap_eff = cap_w;
      end
   end

   assign occ_w    = CW'(occ_ff);
   // valid ranks are 0..occ-1, so the LRU entry is the one holding occ-1
   assign lru_rank = RW'(occ_ff - OW'(1));

   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == request.key);
         if (match[i]) begin
            hit_rank  = hit_rank | rank_ff[i];
            hit_value = hit_value | value_ff[i];
         end
      end
   end

   assign hit = |match;

   assign evict = is_put && (hit ? (occ_w > cap_eff) : (occ_w >= cap_eff));
   assign insert = is_put && !hit;

   always_comb begin
      victim_key = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (match[i]) begin
            rank_a[i] = '0;
         end else if (hit && valid_ff[i] && (rank_ff[i] < hit_rank)) begin
            rank_a[i] = rank_ff[i] + RW'(1);
         end else begin
            rank_a[i] = rank_ff[i];
         end
         lru_sel[i] = valid_ff[i] && (rank_a[i] == lru_rank);
         if (lru_sel[i]) begin
            victim_key = victim_key | key_ff[i];
         end
         valid_b[i] = valid_ff[i] && !(evict && lru_sel[i]);
      end
   end

   // lowest free slot as a one-hot: x & -x
   assign free_vec    = ~valid_b;
   assign free_onehot = free_vec & (~free_vec + MAX_ENTRIES'(1));

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         if (insert) begin
            valid_in[i] = valid_b[i] | free_onehot[i];
            if (free_onehot[i]) begin
               rank_in[i]  = '0;
               key_in[i]   = request.key;
               value_in[i] = request.value;
            end else if (valid_b[i]) begin
               rank_in[i] = rank_a[i] + RW'(1);
            end else begin
               rank_in[i] = '0;
            end
         end else begin
            valid_in[i] = valid_b[i];
            rank_in[i]  = valid_b[i] ? rank_a[i] : '0;
            if (is_put && match[i]) begin
               value_in[i] = request.value;
            end
         end
      end
      occ_in = occ_ff - OW'(evict) + OW'(insert);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (step) begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            key_ff[i]   <= key_in[i];
            value_ff[i] <= value_in[i];
         end
      end
   end

   always_comb begin
      result.hit         = hit;
      result.read_value  = (hit && !is_put) ? hit_value : '0;
      result.evicted     = evict;
      result.evicted_key = evict ? victim_key : '0;
   end

`ifndef SYNTHESIS
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("occupancy does not match valid entries");

   a_unique_key: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("key stored in more than one entry");

   a_evict_lru: assert property (@(posedge clock) disable iff (reset)
      (step && evict) |-> $onehot(lru_sel))
      else $error("eviction without a single LRU entry");

   a_insert_slot: assert property (@(posedge clock) disable iff (reset)
      (step && insert) |-> $onehot(free_onehot))
      else $error("put miss found no free slot");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      (step && insert) |=> (CW'(occ_ff) <= cap_eff) || $stable(occ_ff))
      else $error("insert grew occupancy past capacity");
`endif

endmodule

// File: hdl/lru_key_value_cache.sv
// lru_key_value_cache: top level with request register, capacity CSR and result register.
// Depends on lkvc_pkg and lkvc_table.
`timescale 1ns / 1ps

// Fully associative key-value cache with LRU replacement, MAX_ENTRIES entries.
// Request channel (req_valid/req_stall): req_type 0 = get, 1 = put, with key and value.
// Result channel (rsp_valid/rsp_stall): one result per request, in order: hit flag,
// read value on a get hit, and the evicted key when a put pushes out the LRU entry.
// CSR channel (csr_valid/csr_ready): writes the capacity register (reset 16); write it
// only while no request is in flight. Zero acts as 1, values above MAX_ENTRIES clip.
// An accepted request is held in the request register, looked up from there, and its
// result lands in the result register, which offers it on the result channel.
// Throughput is one request per cycle while rsp_stall does not hold a result, set by the
// combinational parallel key compare and rank update between the two registers.
// Back-to-back requests see each other's table updates with no bubble.
// Reset (synchronous) empties the table and sets capacity to 16.
// When rsp_stall holds a result, the request register keeps its request and
// req_stall rises only once that register is full; nothing is dropped.

module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [VAL_W-1:0]   req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [VAL_W-1:0]   rsp_read_value,
   output logic               rsp_evicted,
   output logic [KEY_W-1:0]   rsp_evicted_key,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CAP_W-1:0]   csr_data
);

   logic               s1_valid_ff, s1_valid_in;
   request_type        s1_req_ff, s1_req_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;
   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   result_type         table_result;
   logic               advance, accept, step;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign step      = s1_valid_ff && advance;
   assign csr_ready = 1'b1;

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (step ? 1'b0 : s1_valid_ff);
      s1_req_in   = s1_req_ff;
      if (accept) begin
         s1_req_in.kind  = req_kind_type'(req_type);
         s1_req_in.key   = req_key;
         s1_req_in.value = req_value;
      end
      rsp_valid_in = step ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_data_in  = step ? table_result : rsp_data_ff;
      capacity_in  = csr_valid ? csr_data : capacity_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= CAPACITY_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         capacity_ff  <= capacity_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff   <= s1_req_in;
      rsp_data_ff <= rsp_data_in;
   end

   lkvc_table #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .capacity (capacity_ff),
      .step     (step),
      .request  (s1_req_ff),
      .result   (table_result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_data_ff.hit;
   assign rsp_read_value  = rsp_data_ff.read_value;
   assign rsp_evicted     = rsp_data_ff.evicted;
   assign rsp_evicted_key = rsp_data_ff.evicted_key;

endmodule

// File: sim/lru_key_value_cache_tb.sv
// lru_key_value_cache_tb: self-checking bench for the LRU key-value cache, with a
// request driver, a response stall generator, and an in-order scoreboard with its own table.
// Depends on lkvc_pkg and lru_key_value_cache.
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
   import lkvc_pkg::*;

   localparam int SLOTS = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int POOL_MAX = 24;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_type = 1'b0;
   logic [KEY_W-1:0] req_key = '0;
   logic [VAL_W-1:0] req_value = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_hit;
   logic [VAL_W-1:0] rsp_read_value;
   logic             rsp_evicted;
   logic [KEY_W-1:0] rsp_evicted_key;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data = '0;

   lru_key_value_cache #(.MAX_ENTRIES(SLOTS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_key(req_key), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_read_value(rsp_read_value), .rsp_evicted(rsp_evicted),
      .rsp_evicted_key(rsp_evicted_key),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // shadow of the cache table
   logic             slot_used [SLOTS];
   logic [KEY_W-1:0] slot_key [SLOTS];
   logic [VAL_W-1:0] slot_val [SLOTS];
   logic [3:0]       slot_age [SLOTS];
   int               used_count = 0;
   logic [CAP_W-1:0] capacity_reg = CAPACITY_RESET;

   request_type      pending [$];
   result_type       results_due [$];
   logic [KEY_W-1:0] key_pool [POOL_MAX];
   int               mismatches = 0;
   int               requests_taken = 0;
   int               gap_left = 0;
   int               stall_left = 0;
   int               cycles = 0;
   logic             long_hold_done = 1'b0;
   logic             steady = 1'b0;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_used[i] = 1'b0;
         slot_age[i] = '0;
      end
   end

   function automatic int effective_capacity();
      if (int'(capacity_reg) == 0) return 1;
      if (int'(capacity_reg) > SLOTS) return SLOTS;
      return int'(capacity_reg);
   endfunction

   function automatic logic evict_oldest(output logic [KEY_W-1:0] victim);
      int oldest;
      oldest = -1;
      victim = '0;
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) oldest = i;
      if (oldest < 0) return 1'b0;
      victim = slot_key[oldest];
      slot_used[oldest] = 1'b0;
      slot_age[oldest] = '0;
      if (used_count > 0) used_count--;
      return 1'b1;
   endfunction

   // applies one request to the shadow table and returns what the cache must answer
   function automatic result_type serve(request_type rq);
      result_type       res;
      int               hit_at, free_at, cap;
      logic [3:0]       age;
      logic [KEY_W-1:0] victim;
      res = '0;
      hit_at = -1;
      free_at = -1;
      victim = '0;
      cap = effective_capacity();
      for (int i = 0; i < SLOTS; i++)
         if (hit_at < 0 && slot_used[i] && slot_key[i] == rq.key) hit_at = i;
      if (hit_at >= 0) begin
         res.hit = 1'b1;
         age = slot_age[hit_at];
         for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_age[i] < age) slot_age[i]++;
         slot_age[hit_at] = '0;
         if (rq.kind == REQ_GET) begin
            res.read_value = slot_val[hit_at];
         end else begin
            slot_val[hit_at] = rq.value;
            // capacity may have been lowered under the current occupancy
            if (used_count > cap) res.evicted = evict_oldest(victim);
         end
      end else if (rq.kind == REQ_PUT) begin
         if (used_count + 1 > cap) res.evicted = evict_oldest(victim);
         for (int i = 0; i < SLOTS; i++)
            if (free_at < 0 && !slot_used[i]) free_at = i;
         if (free_at >= 0) begin
            for (int i = 0; i < SLOTS; i++)
               if (slot_used[i]) slot_age[i]++;
            slot_used[free_at] = 1'b1;
            slot_key[free_at] = rq.key;
            slot_val[free_at] = rq.value;
            slot_age[free_at] = '0;
            used_count++;
         end
      end
      if (res.evicted) res.evicted_key = victim;
      return res;
   endfunction

   function automatic int idle_cycles();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void queue_req(req_kind_type kind, logic [KEY_W-1:0] key,
                                     logic [VAL_W-1:0] value);
      request_type rq;
      rq.kind = kind;
      rq.key = key;
      rq.value = value;
      pending.push_back(rq);
   endfunction

   function automatic request_type random_request(int pool_n);
      request_type rq;
      rq.kind = ($urandom_range(0, 1) != 0) ? REQ_PUT : REQ_GET;
      if ($urandom_range(0, 99) < 85) rq.key = key_pool[$urandom_range(0, pool_n - 1)];
      else rq.key = $urandom;
      rq.value = $urandom;
      return rq;
   endfunction

   function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   task automatic drain();
      do @(negedge clock); while (pending.size() != 0 || req_valid || results_due.size() != 0);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] setting);
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= setting;
      do @(posedge clock); while (!csr_ready);
      capacity_reg = setting;
      csr_valid <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin : driver
      request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending.size() != 0) begin
            next_req = pending.pop_front();
            req_valid <= 1'b1;
            req_type <= next_req.kind;
            req_key <= next_req.key;
            req_value <= next_req.value;
            gap_left <= idle_cycles();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure, including one long hold to fill the pipe
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!long_hold_done && requests_taken >= 275) begin
         rsp_stall <= 1'b1;
         stall_left <= 80;
         long_hold_done <= 1'b1;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_left <= idle_cycles();
      end
   end

   // scoreboard: predict on request accept, check on response accept
   always @(posedge clock) begin : monitor
      request_type seen;
      result_type  want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen.kind = req_kind_type'(req_type);
            seen.key = req_key;
            seen.value = req_value;
            results_due.push_back(serve(seen));
            requests_taken <= requests_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $display("%0t: unexpected response: hit %b read_value %h evicted %b key %h",
                        $time, rsp_hit, rsp_read_value, rsp_evicted, rsp_evicted_key);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               compare_field("hit", 32'(want.hit), 32'(rsp_hit));
               compare_field("read_value", want.read_value, rsp_read_value);
               compare_field("evicted", 32'(want.evicted), 32'(rsp_evicted));
               compare_field("evicted_key", want.evicted_key, rsp_evicted_key);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CAP_W-1:0] phase_caps [8];
      int               pool_n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // capacity at its reset value of 16
      queue_req(REQ_GET, 32'h0, 32'h0);                 // miss on an empty table
      queue_req(REQ_PUT, 32'h0, 32'hFFFF_FFFF);
      queue_req(REQ_PUT, 32'hFFFF_FFFF, 32'h0);
      queue_req(REQ_GET, 32'h0, 32'hDEAD_BEEF);         // value ignored on get
      queue_req(REQ_GET, 32'hFFFF_FFFF, 32'h0);
      queue_req(REQ_PUT, 32'h0, 32'hA5A5_5A5A);         // put hit answers read_value 0
      for (int k = 1; k <= 4; k++) queue_req(REQ_PUT, k, 3 * k);
      drain();

      // lowered below occupancy: only later puts evict
      write_capacity(CAP_W'(2));
      queue_req(REQ_GET, 32'h1, 32'h0);                 // get never evicts
      queue_req(REQ_PUT, 32'h2, 32'h7);                 // put hit trims one entry
      queue_req(REQ_PUT, 32'h63, 32'h5);                // miss over capacity reuses freed slot
      queue_req(REQ_GET, 32'hFFFF_FFFF, 32'h0);
      queue_req(REQ_PUT, 32'h3, 32'h1);
      drain();

      write_capacity(CAP_W'(0));                        // acts as one entry
      queue_req(REQ_PUT, 32'h8, 32'h1);
      queue_req(REQ_PUT, 32'h9, 32'h2);
      queue_req(REQ_GET, 32'h9, 32'h0);
      queue_req(REQ_GET, 32'h8, 32'h0);
      drain();

      write_capacity(CAP_W'(31));                       // clips to the table size
      queue_req(REQ_PUT, 32'h8000_0000, 32'h1);
      queue_req(REQ_PUT, 32'h7FFF_FFFF, 32'h2);
      queue_req(REQ_GET, 32'h8000_0000, 32'h0);
      drain();

      phase_caps = '{CAP_W'(31), CAP_W'(1), CAP_W'(16), CAP_W'(3),
                     CAP_W'(0), CAP_W'(17), CAP_W'($urandom_range(0, 31)), CAP_W'(16)};
      for (int p = 0; p < 8; p++) begin
         write_capacity(phase_caps[p]);
         steady = (p == 2);
         for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
         pool_n = effective_capacity() + $urandom_range(1, 6);
         for (int i = 0; i < 50; i++) pending.push_back(random_request(pool_n));
         drain();
      end
      steady = 1'b0;

      repeat (5) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
